@@ hw/rtl/tcce_pkg.sv @@
// Shared types and constants of the text console character engine.
package tcce_pkg;

    localparam int unsigned SCREEN_LINES = 480;
    localparam int unsigned SCREEN_WIDTH = 640;
    localparam int unsigned JOBQ_DEPTH   = 2;
    localparam int unsigned JOBQ_AW      = $clog2(JOBQ_DEPTH);
    localparam int unsigned JOBQ_CW      = $clog2(JOBQ_DEPTH + 1);

    localparam logic [6:0]  FONT_HEIGHT_RESET = 7'd8;
    localparam logic [7:0]  ATTR_RESET        = 8'h07;

    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_ESC   = 8'h1B;
    localparam logic [7:0]  CH_M     = 8'h6D;
    localparam logic [7:0]  CH_LBRK  = 8'h5B;
    localparam logic [7:0]  CH_SEMI  = 8'h3B;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;

    localparam logic [31:0] CMD_GLYPH_HDR  = 32'h6500_0000;
    localparam logic [31:0] CMD_GLYPH_UV   = 32'h7800_0000;
    localparam logic [31:0] CMD_SCROLL_HDR = 32'h8000_0000;
    localparam logic [31:0] CMD_SCROLL_MID = 32'h0208_0808;

    typedef enum logic [1:0] {
        JOB_GLYPH,
        JOB_SCROLL,
        JOB_ATTR
    } job_kind_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] cur;
        logic [15:0] uv;
        logic [6:0]  fh;
        logic [7:0]  attr0;
        logic [7:0]  attr1;
        logic        two_attr;
    } job_t;

endpackage

@@ hw/rtl/text_console_char_engine_core.sv @@
// Top level of the text console character engine.
//
// Character bytes enter through a queue-style port (push/full) and come out as
// result words through another (empty/pop). The front end takes one character
// per cycle while the job queue has room: it moves the cursor, runs the ANSI
// SGR escape parser and, for a character that yields results, hands a compact
// job to a two-entry job queue. The back end turns each job into its words at
// one word per cycle while the output register is free or popped: a glyph
// gives four words, a scrolling newline seven, an SGR end one or two, and any
// other character none (front end only). The back end's sequencer sets the
// sustained rate of a glyph stream. font_height is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module text_console_char_engine_core
    import tcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // character input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [31:0] word,
    output logic        last
);

    logic accept;
    logic job_push;
    job_t job_in;
    job_t job_head;
    logic job_full;
    logic job_valid;
    logic job_pop;

    assign cfg_ready = 1'b1;
    // hold input whenever the job queue has no room
    assign full      = job_full;
    assign accept    = push && !job_full;

    tcce_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .ch        (ch),
        .job_push  (job_push),
        .job       (job_in)
    );

    tcce_jobq u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .full     (job_full),
        .rd_en    (job_pop),
        .rd_job   (job_head),
        .rd_valid (job_valid)
    );

    tcce_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .word      (word),
        .last      (last)
    );

endmodule

@@ hw/rtl/tcce_front.sv @@
// Front end: takes characters, runs cursor and escape parser, issues jobs.
module tcce_front
    import tcce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [6:0] cfg_data,
    input  logic       accept,
    input  logic [7:0] ch,
    output logic       job_push,
    output job_t       job
);

    logic [6:0]  fh_reg;
    logic [31:0] cursor_reg, cursor_next;
    logic [7:0]  colour_reg, colour_next;
    logic [7:0]  saved_reg, saved_next;
    logic        esc_reg, esc_next;
    phase_t      phase_reg, phase_next;
    logic [9:0]  first_reg, first_next;
    logic [9:0]  second_reg, second_next;
    logic [1:0]  cnt1_reg, cnt1_next;
    logic [1:0]  cnt2_reg, cnt2_next;

    logic        is_digit;
    logic [9:0]  digit_val;
    logic [3:0]  row_shift;
    logic [15:0] uv;
    logic [15:0] y_step;

    // SGR evaluation
    logic [7:0]  base_attr;
    logic        restore;
    logic        have_fg, have_bg, have_set;
    logic [3:0]  fg_code, bg_code, fg_sel;
    logic [7:0]  set_attr;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit_val = {6'd0, ch[3:0]};

    always_comb
    begin
        row_shift = 4'd3;
        for (int i = 6; i >= 0; i--)
        begin
            if (fh_reg[i])
            begin
                row_shift = 4'(i + 4);
            end
        end
    end

    assign uv     = 16'({8'd0, ch[7:4], 4'd0} << row_shift) | {9'd0, ch[3:0], 3'd0};
    assign y_step = cursor_reg[31:16] + {9'd0, fh_reg};

    always_comb
    begin
        base_attr = (first_reg == 10'd0) ? saved_reg : colour_reg;
        restore   = (first_reg == 10'd0);
        have_fg   = 1'b0;
        fg_code   = 4'd0;
        if ((first_reg >= 10'd30) && (first_reg <= 10'd37))
        begin
            have_fg = 1'b1;
            fg_code = 4'(first_reg - 10'd30);
        end
        else if ((first_reg >= 10'd90) && (first_reg <= 10'd97))
        begin
            have_fg = 1'b1;
            fg_code = 4'(first_reg - 10'd82);
        end
        have_bg = 1'b0;
        bg_code = 4'd0;
        if (cnt2_reg != 2'd0)
        begin
            if ((second_reg >= 10'd40) && (second_reg <= 10'd47))
            begin
                have_bg = 1'b1;
                bg_code = 4'(second_reg - 10'd40);
            end
            else if ((second_reg >= 10'd100) && (second_reg <= 10'd107))
            begin
                have_bg = 1'b1;
                bg_code = 4'(second_reg - 10'd92);
            end
        end
        fg_sel   = have_fg ? fg_code : base_attr[3:0];
        have_set = have_fg || have_bg;
        set_attr = have_bg ? {bg_code, fg_sel} : {base_attr[7:4], fg_code};
    end

    // next state
    always_comb
    begin
        cursor_next = cursor_reg;
        colour_next = colour_reg;
        saved_next  = saved_reg;
        esc_next    = esc_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        cnt1_next   = cnt1_reg;
        cnt2_next   = cnt2_reg;
        if (accept)
        begin
            if (esc_reg)
            begin
                if (ch == CH_M)
                begin
                    if (have_set)
                    begin
                        saved_next  = base_attr;
                        colour_next = set_attr;
                    end
                    else if (restore)
                    begin
                        colour_next = base_attr;
                    end
                    esc_next    = 1'b0;
                    phase_next  = PH_WAIT;
                    first_next  = 10'd0;
                    second_next = 10'd0;
                    cnt1_next   = 2'd0;
                    cnt2_next   = 2'd0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_FIRST:
                        begin
                            if (ch == CH_SEMI)
                            begin
                                phase_next = PH_SECOND;
                            end
                            else if (cnt1_reg != 2'd3)
                            begin
                                if (is_digit)
                                begin
                                    first_next = (first_reg << 3) + (first_reg << 1) + digit_val;
                                    cnt1_next  = cnt1_reg + 2'd1;
                                end
                                else
                                begin
                                    cnt1_next = 2'd3;
                                end
                            end
                        end
                        PH_SECOND:
                        begin
                            if (cnt2_reg != 2'd3)
                            begin
                                if (is_digit)
                                begin
                                    second_next = (second_reg << 3) + (second_reg << 1)
                                                  + digit_val;
                                    cnt2_next   = cnt2_reg + 2'd1;
                                end
                                else
                                begin
                                    cnt2_next = 2'd3;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = (ch == CH_LBRK) ? PH_FIRST : PH_WAIT;
                        end
                    endcase
                end
            end
            else if (ch == CH_LF)
            begin
                if (y_step >= 16'(SCREEN_LINES))
                begin
                    cursor_next = {cursor_reg[31:16], 16'd0};
                end
                else
                begin
                    cursor_next = {y_step, 16'd0};
                end
            end
            else if (ch == CH_CR)
            begin
                cursor_next = {cursor_reg[31:16], 16'd0};
            end
            else if (ch == CH_ESC)
            begin
                esc_next   = 1'b1;
                phase_next = PH_WAIT;
            end
            else
            begin
                cursor_next = cursor_reg + 32'd8;
            end
        end
    end

    // job issue
    always_comb
    begin
        job_push      = 1'b0;
        job.kind      = JOB_GLYPH;
        job.cur       = cursor_reg;
        job.uv        = uv;
        job.fh        = fh_reg;
        job.attr0     = have_set && !restore ? set_attr : base_attr;
        job.attr1     = set_attr;
        job.two_attr  = restore && have_set;
        if (accept)
        begin
            if (esc_reg)
            begin
                if ((ch == CH_M) && (restore || have_set))
                begin
                    job_push = 1'b1;
                    job.kind = JOB_ATTR;
                end
            end
            else if (ch == CH_LF)
            begin
                if (y_step >= 16'(SCREEN_LINES))
                begin
                    job_push = 1'b1;
                    job.kind = JOB_SCROLL;
                end
            end
            else if ((ch != CH_CR) && (ch != CH_ESC))
            begin
                job_push = 1'b1;
                job.kind = JOB_GLYPH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg     <= FONT_HEIGHT_RESET;
            cursor_reg <= 32'd0;
            colour_reg <= ATTR_RESET;
            saved_reg  <= ATTR_RESET;
            esc_reg    <= 1'b0;
            phase_reg  <= PH_WAIT;
            first_reg  <= 10'd0;
            second_reg <= 10'd0;
            cnt1_reg   <= 2'd0;
            cnt2_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fh_reg <= cfg_data;
            end
            cursor_reg <= cursor_next;
            colour_reg <= colour_next;
            saved_reg  <= saved_next;
            esc_reg    <= esc_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            cnt1_reg   <= cnt1_next;
            cnt2_reg   <= cnt2_next;
        end
    end

endmodule

@@ hw/rtl/tcce_jobq.sv @@
// Short job queue between the front end and the word sequencer.
module tcce_jobq
    import tcce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic rd_valid
);

    job_t                slot_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]  wp_reg, rp_reg;
    logic [JOBQ_CW-1:0]  count_reg;

    assign full     = (count_reg == JOBQ_CW'(JOBQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            count_reg <= count_reg + JOBQ_CW'(wr_en) - JOBQ_CW'(rd_en);
        end
    end

endmodule

@@ hw/rtl/tcce_back.sv @@
// Back end: expands a job into its words, one per cycle unless stalled.
module tcce_back
    import tcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [31:0] word,
    output logic        last
);

    logic [2:0]  step_reg, step_next;
    logic        oval_reg, oval_next;
    logic        kind_reg;
    logic [31:0] word_reg;
    logic        last_reg;

    logic        load;
    logic        w_kind;
    logic [31:0] w_word;
    logic        w_last;
    logic [31:0] h;
    logic [31:0] bottom;

    assign h      = {9'd0, job.fh, 16'd0};
    assign bottom = {16'(SCREEN_LINES) - {9'd0, job.fh}, 16'd0};
    assign load   = job_valid && (!oval_reg || pop);

    always_comb
    begin
        w_kind = 1'b0;
        w_word = 32'd0;
        w_last = 1'b0;
        unique case (job.kind)
            JOB_GLYPH:
            begin
                w_last = (step_reg == 3'd3);
                unique case (step_reg)
                    3'd0:    w_word = CMD_GLYPH_HDR;
                    3'd1:    w_word = job.cur;
                    3'd2:    w_word = CMD_GLYPH_UV | {16'd0, job.uv};
                    default: w_word = h | 32'd8;
                endcase
            end
            JOB_SCROLL:
            begin
                w_last = (step_reg == 3'd6);
                unique case (step_reg)
                    3'd0:    w_word = CMD_SCROLL_HDR;
                    3'd1:    w_word = h;
                    3'd2:    w_word = 32'd0;
                    3'd3:    w_word = bottom | 32'(SCREEN_WIDTH);
                    3'd4:    w_word = CMD_SCROLL_MID;
                    3'd5:    w_word = bottom;
                    default: w_word = h | 32'(SCREEN_WIDTH);
                endcase
            end
            JOB_ATTR:
            begin
                w_kind = 1'b1;
                w_last = job.two_attr ? (step_reg == 3'd1) : 1'b1;
                w_word = {24'd0, (step_reg == 3'd0) ? job.attr0 : job.attr1};
            end
            default:
            begin
                w_last = 1'b1;
            end
        endcase
    end

    assign job_pop = load && w_last;

    always_comb
    begin
        step_next = step_reg;
        oval_next = oval_reg;
        if (load)
        begin
            step_next = w_last ? 3'd0 : step_reg + 3'd1;
            oval_next = 1'b1;
        end
        else if (pop)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= w_kind;
            word_reg <= w_word;
            last_reg <= w_last;
        end
    end

    assign empty = !oval_reg;
    assign kind  = kind_reg;
    assign word  = word_reg;
    assign last  = last_reg;

endmodule
